// ===== rtl/core/two_key_priority_queue_unit_macros.svh =====
// Assertion macros for the two-key priority queue unit.
`ifndef TWO_KEY_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define TWO_KEY_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TKPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define TKPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/tkpq_pkg.sv =====
// Package with the item types, cell control type and codes of the priority queue.
`default_nettype none
package tkpq_pkg;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  typedef struct packed {
    logic [7:0]  severity;
    logic [15:0] duration;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  severity;
    logic [15:0] duration;
    logic [15:0] tag;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        head_valid;
    logic [7:0]  head_severity;
    logic [15:0] head_duration;
    logic [15:0] head_tag;
    logic [4:0]  count;
    logic        is_full;
  } result_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/tkpq_cell.sv =====
// One cell of the sorted queue: holds one entry and trades it with its neighbors.
`default_nettype none
module tkpq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  wire                       clk,
  input  wire tkpq_pkg::cell_ctrl_t ctrl,
  input  wire [CW-1:0]              count,
  input  wire tkpq_pkg::entry_t     prev_q,
  input  wire                       prev_behind,
  input  wire tkpq_pkg::entry_t     next_q,
  output tkpq_pkg::entry_t          q,
  output logic                      behind,
  output tkpq_pkg::entry_t          q_next
);
  import tkpq_pkg::*;

  logic occ;

  assign occ = CW'(IDX) < count;

  always_comb begin
    behind = occ && ((q.severity > ctrl.ent.severity) ||
                     ((q.severity == ctrl.ent.severity) &&
                      (q.duration <= ctrl.ent.duration)));
  end

  always_comb begin
    q_next = q;
    if (ctrl.enq) begin
      if (!behind) begin
        q_next = prev_behind ? ctrl.ent : prev_q;
      end
    end else if (ctrl.deq) begin
      q_next = next_q;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/two_key_priority_queue_unit.sv =====
// Top level of the two-key priority queue: cell row, entry count, result register, APB port.
// The queue is a row of DEPTH cells kept sorted at all times, highest severity first, then
// shorter duration, then arrival order. Every cell compares the incoming entry with its own
// and all cells shift together, so one item can be accepted per clock while the result
// register is free, and its result sits in the output register from the next cycle on. The
// result register frees the input side whenever it is empty or being taken. The entry storage
// needs no clearing after reset; the count alone marks which cells hold entries. Capacity is
// written through the APB port at address 0 and is clamped to the range 1 to DEPTH.
`default_nettype none
module two_key_priority_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            item_valid,
  output logic                           item_ready,
  input  wire tkpq_pkg::item_t           item,
  output logic                           result_valid,
  input  wire                            result_ready,
  output tkpq_pkg::result_t              result,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [tkpq_pkg::ADDR_W-1:0]     paddr,
  input  wire [31:0]                     pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tkpq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (CW > 5) ? CW : 5;

  logic [4:0]    capacity;
  logic [4:0]    cap_min;
  logic [EW-1:0] cap_eff;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  logic          full_next;
  cell_ctrl_t    ctrl;
  entry_t        head_next;
  result_t       result_next;
  entry_t        q_row      [DEPTH];
  logic          behind_row [DEPTH];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {27'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[4:0];
    end
  end

  assign cap_min = (capacity == 5'd0) ? 5'd1 : capacity;
  assign cap_eff = (EW'(cap_min) > EW'(DEPTH)) ? EW'(DEPTH) : EW'(cap_min);

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign full       = EW'(count) >= cap_eff;
  assign empty      = count == '0;

  always_comb begin
    ctrl.enq          = accept && (item.func == FUNC_ENQ) && !full;
    ctrl.deq          = accept && (item.func == FUNC_DEQ) && !empty;
    ctrl.ent.severity = item.severity;
    ctrl.ent.duration = item.duration;
    ctrl.ent.tag      = item.tag;
  end

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + CW'(1);
    end else if (ctrl.deq) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      tkpq_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .count       (count),
        .prev_q      (ctrl.ent),
        .prev_behind (1'b1),
        .next_q      (q_row[(DEPTH > 1) ? 1 : 0]),
        .q           (q_row[i]),
        .behind      (behind_row[i]),
        .q_next      (head_next)
      );
    end else if (i == DEPTH - 1) begin : g_last
      tkpq_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .count       (count),
        .prev_q      (q_row[i-1]),
        .prev_behind (behind_row[i-1]),
        .next_q      (q_row[i]),
        .q           (q_row[i]),
        .behind      (behind_row[i]),
        .q_next      ()
      );
    end else begin : g_mid
      tkpq_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .count       (count),
        .prev_q      (q_row[i-1]),
        .prev_behind (behind_row[i-1]),
        .next_q      (q_row[i+1]),
        .q           (q_row[i]),
        .behind      (behind_row[i]),
        .q_next      ()
      );
    end
  end

  assign full_next = EW'(count_next) >= cap_eff;

  always_comb begin
    result_next.status = STATUS_DONE;
    if ((item.func == FUNC_ENQ) && full) begin
      result_next.status = STATUS_FULL;
    end else if ((item.func == FUNC_DEQ) && empty) begin
      result_next.status = STATUS_EMPTY;
    end
    result_next.head_valid    = count_next != '0;
    result_next.head_severity = result_next.head_valid ? head_next.severity : 8'd0;
    result_next.head_duration = result_next.head_valid ? head_next.duration : 16'd0;
    result_next.head_tag      = result_next.head_valid ? head_next.tag : 16'd0;
    result_next.count         = 5'(count_next);
    result_next.is_full       = full_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tkpq_checker.sv =====
// Port-level checker for the two-key priority queue and its bind to the top level.
`default_nettype none
`include "two_key_priority_queue_unit_macros.svh"
module tkpq_checker (
  input wire                    clk,
  input wire                    rst,
  input wire                    result_valid,
  input wire tkpq_pkg::result_t result
);
  import tkpq_pkg::*;

  `TKPQ_ASSERT(a_head_matches_count, clk, rst, result_valid |-> (result.head_valid == (result.count != 5'd0)), "head_valid disagrees with count")
  `TKPQ_ASSERT(a_empty_head_zero, clk, rst, (result_valid && !result.head_valid) |-> ((result.head_severity == 8'd0) && (result.head_duration == 16'd0) && (result.head_tag == 16'd0)), "empty queue shows a nonzero head")
  `TKPQ_ASSERT(a_reject_means_full, clk, rst, (result_valid && (result.status == STATUS_FULL)) |-> result.is_full, "rejected enqueue without full flag")
  `TKPQ_ASSERT(a_ignore_means_empty, clk, rst, (result_valid && (result.status == STATUS_EMPTY)) |-> (result.count == 5'd0), "ignored dequeue with entries held")
  `TKPQ_ASSERT_ALWAYS(a_reset_clears_valid, clk, ($past(rst) && !rst) |-> !result_valid, "result valid right after reset")

endmodule

bind two_key_priority_queue_unit tkpq_checker u_tkpq_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result       (result)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the two-key priority queue unit: directed table plus random traffic.
`timescale 1ns / 1ps
module tb_top;
  import tkpq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_ITEMS = 105;
  localparam int PHASES = 8;
  localparam int REG_SPARE = 1;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    item_t       it;
    int          idx;
    logic [31:0] wdata;
    bit          typed;
    result_t     want;
  } stim_row_t;

  typedef struct {
    bit      typed;
    result_t want;
  } known_head_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  entry_t                pq_entries [QDEPTH];
  int                    pq_count = 0;
  logic [4:0]            pq_cap = CAPACITY_RESET;
  result_t               pending_heads [$];
  known_head_t           typed_heads [$];
  stim_row_t             dir_rows [$];
  int                    mismatches = 0;
  int                    idle_cycles = 0;
  bit                    calm = 1'b0;

  two_key_priority_queue_unit #(.DEPTH(QDEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t apply_queue_op(item_t it);
    int eff;
    int pos;
    int k;
    result_t r;
    eff = (pq_cap == 0) ? 1 : ((pq_cap > QDEPTH) ? QDEPTH : int'(pq_cap));
    r = '0;
    r.status = STATUS_DONE;
    if (it.func == FUNC_ENQ) begin
      if (pq_count >= eff) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < pq_count && (pq_entries[pos].severity > it.severity ||
               (pq_entries[pos].severity == it.severity &&
                pq_entries[pos].duration <= it.duration))) begin
          pos++;
        end
        for (k = pq_count; k > pos; k--) begin
          pq_entries[k] = pq_entries[k-1];
        end
        pq_entries[pos].severity = it.severity;
        pq_entries[pos].duration = it.duration;
        pq_entries[pos].tag = it.tag;
        pq_count++;
      end
    end else if (pq_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      for (k = 0; k + 1 < pq_count; k++) begin
        pq_entries[k] = pq_entries[k+1];
      end
      pq_count--;
    end
    if (pq_count > 0) begin
      r.head_valid = 1'b1;
      r.head_severity = pq_entries[0].severity;
      r.head_duration = pq_entries[0].duration;
      r.head_tag = pq_entries[0].tag;
    end
    r.count = 5'(pq_count);
    r.is_full = (pq_count >= eff);
    return r;
  endfunction

  function automatic item_t make_item(logic func, logic [7:0] sev, logic [15:0] dur,
                                      logic [15:0] tag);
    item_t it;
    it.func = func;
    it.severity = sev;
    it.duration = dur;
    it.tag = tag;
    return it;
  endfunction

  function automatic result_t head_report(logic [1:0] st, logic v, logic [7:0] sev,
                                          logic [15:0] dur, logic [15:0] tag,
                                          logic [4:0] cnt, logic full);
    result_t r;
    r.status = st;
    r.head_valid = v;
    r.head_severity = sev;
    r.head_duration = dur;
    r.head_tag = tag;
    r.count = cnt;
    r.is_full = full;
    return r;
  endfunction

  function automatic void item_row(logic func, logic [7:0] sev, logic [15:0] dur,
                                   logic [15:0] tag, bit typed, result_t want);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.it = make_item(func, sev, dur, tag);
    row.idx = 0;
    row.wdata = '0;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void write_row(int idx, logic [31:0] data);
    stim_row_t row;
    row.kind = ROW_WRITE;
    row.it = '0;
    row.idx = idx;
    row.wdata = data;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic item_t random_item(logic func);
    logic [7:0] sev;
    logic [15:0] dur;
    case ($urandom_range(0, 4))
      0: sev = 8'h00;
      1: sev = 8'hFF;
      2: sev = 8'h80;
      3: sev = 8'h7F;
      default: sev = 8'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0: dur = 16'h0000;
      1: dur = 16'hFFFF;
      2: dur = 16'h8000;
      3: dur = 16'h0001;
      default: dur = 16'($urandom());
    endcase
    if (func == FUNC_DEQ) begin
      sev = 8'($urandom());
      dur = 16'($urandom());
    end
    return make_item(func, sev, dur, 16'($urandom()));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_head(result_t got, result_t want);
    if (got.status !== want.status)
      note_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.head_valid !== want.head_valid)
      note_mismatch($sformatf("head_valid got %0d want %0d", got.head_valid, want.head_valid));
    if (got.head_severity !== want.head_severity)
      note_mismatch($sformatf("head_severity got %0h want %0h", got.head_severity,
                              want.head_severity));
    if (got.head_duration !== want.head_duration)
      note_mismatch($sformatf("head_duration got %0h want %0h", got.head_duration,
                              want.head_duration));
    if (got.head_tag !== want.head_tag)
      note_mismatch($sformatf("head_tag got %0h want %0h", got.head_tag, want.head_tag));
    if (got.count !== want.count)
      note_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
    if (got.is_full !== want.is_full)
      note_mismatch($sformatf("is_full got %0d want %0d", got.is_full, want.is_full));
  endtask

  task automatic send_item(item_t it, bit typed, result_t want);
    int gap;
    logic [63:0] junk;
    known_head_t k;
    gap = pick_gap();
    if (gap != 0) begin
      junk = {$urandom(), $urandom()};
      item_valid <= 1'b0;
      item <= junk[40:0];
      repeat (gap) @(posedge clk);
    end
    k.typed = typed;
    k.want = want;
    typed_heads.push_back(k);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic write_reg(int idx, logic [31:0] data);
    item_valid <= 1'b0;
    while (pending_heads.size() != 0 || typed_heads.size() != 0) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == int'(REG_CAPACITY)) begin
      pq_cap = data[4:0];
    end
  endtask

  always @(posedge clk) begin : monitor
    known_head_t k;
    result_t pred;
    result_t want;
    bit busy;
    if (!rst) begin
      busy = 1'b0;
      if (item_valid && item_ready) begin
        busy = 1'b1;
        pred = apply_queue_op(item);
        if (typed_heads.size() != 0) begin
          k = typed_heads.pop_front();
          if (k.typed) begin
            pred = k.want;
          end
        end
        pending_heads.push_back(pred);
      end
      if (result_valid && result_ready) begin
        busy = 1'b1;
        if (pending_heads.size() == 0) begin
          note_mismatch("result with no expected head");
        end else begin
          want = pending_heads.pop_front();
          check_head(result, want);
        end
      end
      if (psel && penable) begin
        busy = 1'b1;
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else if (calm) begin
        result_ready <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        result_ready <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
        result_ready <= 1'b1;
        hold = $urandom_range(0, 12);
      end
    end
  end

  initial begin : stimulus
    int ph;
    int sent;
    int run;
    int n;
    logic [4:0] cap;
    logic dir;
    logic func;

    item_row(FUNC_DEQ, 8'hFF, 16'hFFFF, 16'hFFFF, 1,
             head_report(STATUS_EMPTY, 1'b0, 8'h00, 16'h0000, 16'h0000, 5'd0, 1'b0));
    item_row(FUNC_ENQ, 8'h00, 16'h0000, 16'h0000, 1,
             head_report(STATUS_DONE, 1'b1, 8'h00, 16'h0000, 16'h0000, 5'd1, 1'b0));
    item_row(FUNC_ENQ, 8'hFF, 16'hFFFF, 16'hFFFF, 1,
             head_report(STATUS_DONE, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd2, 1'b0));
    item_row(FUNC_ENQ, 8'hFF, 16'h0000, 16'h1234, 1,
             head_report(STATUS_DONE, 1'b1, 8'hFF, 16'h0000, 16'h1234, 5'd3, 1'b0));
    item_row(FUNC_ENQ, 8'hFF, 16'h0000, 16'hAAAA, 1,
             head_report(STATUS_DONE, 1'b1, 8'hFF, 16'h0000, 16'h1234, 5'd4, 1'b0));
    item_row(FUNC_DEQ, 8'h55, 16'h5555, 16'h5555, 1,
             head_report(STATUS_DONE, 1'b1, 8'hFF, 16'h0000, 16'hAAAA, 5'd3, 1'b0));
    item_row(FUNC_DEQ, 8'h00, 16'h0000, 16'h0000, 1,
             head_report(STATUS_DONE, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd2, 1'b0));
    item_row(FUNC_DEQ, 8'hAA, 16'hAAAA, 16'hAAAA, 1,
             head_report(STATUS_DONE, 1'b1, 8'h00, 16'h0000, 16'h0000, 5'd1, 1'b0));
    item_row(FUNC_DEQ, 8'h00, 16'h0000, 16'h0000, 1,
             head_report(STATUS_DONE, 1'b0, 8'h00, 16'h0000, 16'h0000, 5'd0, 1'b0));
    // A capacity of zero acts as one.
    write_row(int'(REG_CAPACITY), 32'hFFFF_FFE0);
    item_row(FUNC_ENQ, 8'h80, 16'h8000, 16'h5A5A, 1,
             head_report(STATUS_DONE, 1'b1, 8'h80, 16'h8000, 16'h5A5A, 5'd1, 1'b1));
    item_row(FUNC_ENQ, 8'hFF, 16'h0000, 16'h0001, 1,
             head_report(STATUS_FULL, 1'b1, 8'h80, 16'h8000, 16'h5A5A, 5'd1, 1'b1));
    write_row(int'(REG_CAPACITY), 32'd3);
    item_row(FUNC_ENQ, 8'h80, 16'h8000, 16'h0001, 0, '0);
    item_row(FUNC_ENQ, 8'h80, 16'h7FFF, 16'h0002, 0, '0);
    item_row(FUNC_ENQ, 8'h01, 16'h0001, 16'h0003, 1,
             head_report(STATUS_FULL, 1'b1, 8'h80, 16'h7FFF, 16'h0002, 5'd3, 1'b1));
    // Capacity below the count keeps every entry and rejects enqueues.
    write_row(int'(REG_CAPACITY), 32'd2);
    item_row(FUNC_ENQ, 8'hFF, 16'h0000, 16'h0000, 1,
             head_report(STATUS_FULL, 1'b1, 8'h80, 16'h7FFF, 16'h0002, 5'd3, 1'b1));
    item_row(FUNC_DEQ, 8'h00, 16'h0000, 16'h0000, 0, '0);
    item_row(FUNC_DEQ, 8'h00, 16'h0000, 16'h0000, 0, '0);
    // A write to an unused register index must leave capacity alone.
    write_row(REG_SPARE, 32'd31);
    item_row(FUNC_ENQ, 8'h80, 16'h8000, 16'h0004, 0, '0);
    item_row(FUNC_ENQ, 8'h81, 16'hFFFF, 16'h0005, 0, '0);
    write_row(int'(REG_CAPACITY), 32'd31);
    item_row(FUNC_ENQ, 8'h81, 16'hFFFF, 16'h0006, 0, '0);
    item_row(FUNC_DEQ, 8'h00, 16'h0000, 16'h0000, 0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_ITEM) begin
        send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      end else begin
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: cap = 5'd16;
        1: cap = 5'd31;
        2: cap = 5'd1;
        3: cap = 5'd0;
        4: cap = 5'd17;
        default: cap = 5'($urandom_range(0, 31));
      endcase
      write_reg(int'(REG_CAPACITY), {27'($urandom()), cap});
      calm = (ph % 3 == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        dir = ($urandom_range(0, 9) < 6) ? FUNC_ENQ : FUNC_DEQ;
        run = $urandom_range(1, 20);
        for (n = 0; n < run && sent < PHASE_ITEMS; n++) begin
          func = ($urandom_range(0, 7) == 0) ? ~dir : dir;
          send_item(random_item(func), 1'b0, '0);
          sent++;
        end
      end
    end
    calm = 1'b0;
    item_valid <= 1'b0;

    while (pending_heads.size() != 0 || typed_heads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tkpq_pkg.sv
rtl/core/tkpq_cell.sv
rtl/core/two_key_priority_queue_unit.sv
rtl/core/tkpq_checker.sv
sim/tb_top.sv
